// ===== rtl/core/bcad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcad_pkg
// Shared widths, codes and types of the binary code asymmetric distance block.
// ----------------------------------------------------------------------------
package bcad_pkg;

    localparam int LANES       = 8;
    localparam int LANE_SH     = 3;
    localparam int MAX_DIM_DEF = 1024;

    localparam int QW         = 16;
    localparam int TERM_W     = QW + 1;
    localparam int QIDX_W     = 10;
    localparam int CODE_W     = 8;
    localparam int SCALE_W    = 16;
    localparam int ROW_W      = 20;
    localparam int SCORE_W    = 48;
    localparam int RDIM_W     = 11;
    localparam int RCNT_W     = 21;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam int FIFO_D = 8;

    localparam logic [RDIM_W-1:0] ROUTE_DIM_RST = 11'd1024;
    localparam logic [RCNT_W-1:0] ROW_COUNT_RST = 21'h100000;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROUTE_DIM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic               err;
        logic [SCALE_W-1:0] scale;
        logic [ROW_W-1:0]   row;
    } t_ctrl;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ROW_W-1:0]   row;
        logic               err;
    } t_result;

endpackage

// ===== rtl/core/binary_code_asymmetric_distance_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_code_asymmetric_distance_top
// One-bit quantized asymmetric distance over streamed sign-bit row codes.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock: a load writes one query
// element, a score transaction carries one code byte that eight lanes apply
// in parallel, each lane reading its own bank of the query store once per
// cycle. A row's score passes the lane, sum, product and output registers
// into a result queue of eight entries; the input stalls only while that
// queue and the score pipeline together hold eight pending results. The
// query store needs no clearing after reset, and its entries must be loaded
// before a row reads them.
// ----------------------------------------------------------------------------
module binary_code_asymmetric_distance_top
    import bcad_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [9:0] query_index, [25:10] query_value, [33:26] code_byte,
    // [49:34] row_scale, [69:50] row_id, [71:70] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic [0:0]            s_axis_tuser,
    input  logic                  s_axis_tlast,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [47:0] score, [67:48] scored_row, [71:68] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] id_error
    output logic [0:0]            m_axis_tuser,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int BANK_D = MAX_DIM / LANES;
    localparam int AW     = (BANK_D > 1) ? $clog2(BANK_D) : 1;
    localparam int BC_W   = $clog2(BANK_D + 1);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CR_W   = $clog2(FIFO_D + 1);

    logic [RDIM_W-1:0]  r_route_dim;
    logic [RCNT_W-1:0]  r_row_count;
    logic [BC_W-1:0]    r_bc;
    logic [CR_W-1:0]    r_credits;

    logic               in_acc;
    logic               is_score;
    logic               load_wr;
    logic               out_acc;
    logic [QIDX_W-1:0]  qidx;
    logic signed [QW-1:0] qval;
    logic [CODE_W-1:0]  code;
    logic [SCALE_W-1:0] scale;
    logic [ROW_W-1:0]   row_id;

    logic [31:0]        route32;
    logic [31:0]        dim32;
    logic [DIM_W-1:0]   dim;
    logic [31:0]        wr_word32;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        bc32;
    logic [AW-1:0]      rd_addr;
    logic [LANES-1:0]   lane_en;

    t_ctrl              n_s1_ctrl;
    t_ctrl              r_s1_ctrl;
    t_ctrl              r_s2_ctrl;
    logic [LANES-1:0]   r_s1_code;
    logic [LANES-1:0]   r_s1_en;

    logic signed [TERM_W-1:0] terms [LANES];

    logic               push;
    t_result            push_data;
    t_result            head;

    assign qidx   = s_axis_tdata[9:0];
    assign qval   = signed'(s_axis_tdata[25:10]);
    assign code   = s_axis_tdata[33:26];
    assign scale  = s_axis_tdata[49:34];
    assign row_id = s_axis_tdata[69:50];

    assign s_axis_tready = (r_credits < CR_W'(FIFO_D));
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign is_score      = in_acc & (s_axis_tuser[0] == OP_SCORE);
    assign load_wr       = in_acc & (s_axis_tuser[0] == OP_LOAD)
                         & (32'(qidx) < 32'(MAX_DIM));
    assign out_acc       = m_axis_tvalid & m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        route32   = 32'(r_route_dim);
        dim32     = (route32 < 32'(MAX_DIM)) ? route32 : 32'(MAX_DIM);
        dim       = dim32[DIM_W-1:0];
        wr_word32 = 32'(qidx >> LANE_SH);
        wr_addr   = wr_word32[AW-1:0];
        bc32      = 32'(r_bc);
        rd_addr   = bc32[AW-1:0];
        for (int l = 0; l < LANES; l++) begin
            lane_en[l] = ((bc32 << LANE_SH) + 32'(l)) < dim32;
        end
        n_s1_ctrl.valid = is_score;
        n_s1_ctrl.last  = s_axis_tlast;
        n_s1_ctrl.err   = {1'b0, row_id} >= r_row_count;
        n_s1_ctrl.scale = scale;
        n_s1_ctrl.row   = row_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_dim <= ROUTE_DIM_RST;
            r_row_count <= ROW_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROUTE_DIM: r_route_dim <= i_cfg_data[RDIM_W-1:0];
                REG_ROW_COUNT: r_row_count <= i_cfg_data[RCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc      <= '0;
            r_credits <= '0;
        end else begin
            if (is_score) begin
                if (s_axis_tlast) begin
                    r_bc <= '0;
                end else if (r_bc < BC_W'(BANK_D)) begin
                    r_bc <= r_bc + 1'b1;
                end
            end
            r_credits <= r_credits + CR_W'(is_score & s_axis_tlast) - CR_W'(out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctrl <= '0;
            r_s2_ctrl <= '0;
        end else begin
            r_s1_ctrl <= n_s1_ctrl;
            r_s2_ctrl <= r_s1_ctrl;
        end
        r_s1_code <= code;
        r_s1_en   <= lane_en;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        bcad_lane #(
            .BANK_D (BANK_D)
        ) u_lane (
            .i_clk   (i_clk),
            .i_we    (load_wr & (qidx[LANE_SH-1:0] == LANE_SH'(l))),
            .i_waddr (wr_addr),
            .i_wdata (qval),
            .i_raddr (rd_addr),
            .i_bit   (r_s1_code[l]),
            .i_en    (r_s1_en[l] & r_s1_ctrl.valid),
            .o_term  (terms[l])
        );
    end

    bcad_merge #(
        .MAX_DIM (MAX_DIM)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_terms  (terms),
        .i_ctrl   (r_s2_ctrl),
        .i_dim    (dim),
        .o_push   (push),
        .o_result (push_data)
    );

    bcad_fifo #(
        .DEPTH (FIFO_D)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (head)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - SCORE_W - ROW_W){1'b0}}, head.row, head.score};
    assign m_axis_tuser = head.err;

endmodule

// ===== rtl/core/bcad_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcad_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module bcad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bcad_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcad_lane
// One lane: a bank of the query store and the signed term of one code bit.
// ----------------------------------------------------------------------------
module bcad_lane
    import bcad_pkg::*;
#(
    parameter int BANK_D = MAX_DIM_DEF / LANES,
    localparam int AW    = (BANK_D > 1) ? $clog2(BANK_D) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [QW-1:0]     i_wdata,
    input  logic [AW-1:0]            i_raddr,
    input  logic                     i_bit,
    input  logic                     i_en,
    output logic signed [TERM_W-1:0] o_term
);

    logic [QW-1:0]            q_raw;
    logic signed [TERM_W-1:0] q_ext;
    logic signed [TERM_W-1:0] n_term;
    logic signed [TERM_W-1:0] r_term;

    bcad_ram #(
        .WIDTH (QW),
        .DEPTH (BANK_D)
    ) u_bank (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr),
        .o_rdata (q_raw)
    );

    always_comb begin
        q_ext = signed'({q_raw[QW-1], q_raw});
        if (!i_en) begin
            n_term = '0;
        end else if (i_bit) begin
            n_term = q_ext;
        end else begin
            n_term = -q_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
    end

    assign o_term = r_term;

endmodule

// ===== rtl/core/bcad_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcad_merge
// Sums the lane terms into the row dot product and forms the scaled score.
// ----------------------------------------------------------------------------
module bcad_merge
    import bcad_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    localparam int DIM_W  = $clog2(MAX_DIM + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [TERM_W-1:0] i_terms [LANES],
    input  t_ctrl                    i_ctrl,
    input  logic [DIM_W-1:0]         i_dim,
    output logic                     o_push,
    output t_result                  o_result
);

    localparam int ACC_W  = TERM_W + $clog2(MAX_DIM);
    localparam int SD_W   = ACC_W + SCALE_W + 1;
    localparam int DSS_W  = DIM_W + 2 * SCALE_W;
    localparam int MAX_A  = (DSS_W > SD_W + 5) ? DSS_W : SD_W + 5;
    localparam int MAX_B  = (MAX_A > SCORE_W) ? MAX_A : SCORE_W;
    localparam int FULL_W = MAX_B + 2;

    localparam logic signed [FULL_W-1:0] S_MAX =
        {{(FULL_W - SCORE_W + 1){1'b0}}, {(SCORE_W - 1){1'b1}}};
    localparam logic signed [FULL_W-1:0] S_MIN =
        {{(FULL_W - SCORE_W + 1){1'b1}}, {(SCORE_W - 1){1'b0}}};

    logic signed [ACC_W-1:0]  lane_sum;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  r_acc;

    t_ctrl                    n_s3_ctrl;
    t_ctrl                    r_s3_ctrl;
    logic signed [ACC_W-1:0]  r_s3_dot;

    t_ctrl                    r_s4_ctrl;
    logic [2*SCALE_W-1:0]     r_s4_ss;
    logic signed [SD_W-1:0]   r_s4_sd;

    t_ctrl                    r_s5_ctrl;
    logic [DSS_W-1:0]         r_s5_dss;
    logic signed [SD_W-1:0]   r_s5_sd;

    logic signed [SCALE_W:0]  scale_s;
    logic signed [FULL_W-1:0] dss_f;
    logic signed [FULL_W-1:0] sd_f;
    logic signed [FULL_W-1:0] full;
    logic [SCORE_W-1:0]       sat;

    logic                     r_out_valid;
    t_result                  r_out;

    always_comb begin
        lane_sum = '0;
        for (int l = 0; l < LANES; l++) begin
            lane_sum = lane_sum + ACC_W'(i_terms[l]);
        end
        acc_next = r_acc + lane_sum;
        n_s3_ctrl       = i_ctrl;
        n_s3_ctrl.valid = i_ctrl.valid & i_ctrl.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc           <= '0;
            r_s3_ctrl.valid <= 1'b0;
        end else begin
            if (i_ctrl.valid) begin
                r_acc <= i_ctrl.last ? '0 : acc_next;
            end
            r_s3_ctrl <= n_s3_ctrl;
        end
        r_s3_dot <= acc_next;
    end

    assign scale_s = signed'({1'b0, r_s3_ctrl.scale});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctrl.valid <= 1'b0;
            r_s5_ctrl.valid <= 1'b0;
        end else begin
            r_s4_ctrl <= r_s3_ctrl;
            r_s5_ctrl <= r_s4_ctrl;
        end
        r_s4_ss  <= (2*SCALE_W)'(r_s3_ctrl.scale) * (2*SCALE_W)'(r_s3_ctrl.scale);
        r_s4_sd  <= SD_W'(scale_s) * SD_W'(r_s3_dot);
        r_s5_dss <= DSS_W'(i_dim) * DSS_W'(r_s4_ss);
        r_s5_sd  <= r_s4_sd;
    end

    // s*s has 24 fraction bits, s*dot has 20: 2*s*dot aligns as 32*s*dot
    always_comb begin
        dss_f = signed'(FULL_W'(r_s5_dss));
        sd_f  = FULL_W'(r_s5_sd);
        full  = dss_f - (sd_f <<< 5);
        if (full > S_MAX) begin
            sat = S_MAX[SCORE_W-1:0];
        end else if (full < S_MIN) begin
            sat = S_MIN[SCORE_W-1:0];
        end else begin
            sat = full[SCORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s5_ctrl.valid;
        end
        r_out.score <= r_s5_ctrl.err ? '0 : sat;
        r_out.row   <= r_s5_ctrl.row;
        r_out.err   <= r_s5_ctrl.err;
    end

    assign o_push   = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/core/bcad_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcad_fifo
// Result queue between the score pipeline and the output stream.
// ----------------------------------------------------------------------------
module bcad_fifo
    import bcad_pkg::*;
#(
    parameter int DEPTH = FIFO_D,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_data
);

    t_result       r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          pop_ok;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop_ok  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(pop_ok);
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== bench/tb_binary_code_asymmetric_distance_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_code_asymmetric_distance_top
// Self-checking bench for the binary code asymmetric distance block.
// ----------------------------------------------------------------------------
// A queue of input transactions, filled by the stimulus process, feeds a
// stream driver with random gaps; the result side stalls at random. The
// bench keeps its own copy of the query store, the running dot product and
// the two registers, predicts each row score as input transactions are
// accepted and checks every result field by field in order. Query entries
// are only ever read by rows after they have been loaded.
// ----------------------------------------------------------------------------
module tb_binary_code_asymmetric_distance_top;
    import bcad_pkg::*;

    localparam int QDEPTH    = MAX_DIM_DEF;
    localparam int MAX_BYTES = QDEPTH / LANES;
    localparam longint SCORE_HI = (longint'(1) <<< (SCORE_W - 1)) - 1;
    localparam longint SCORE_LO = -(longint'(1) <<< (SCORE_W - 1));

    typedef struct {
        logic                op;
        logic [QIDX_W-1:0]   qidx;
        logic [QW-1:0]       qval;
        logic [CODE_W-1:0]   code;
        logic [SCALE_W-1:0]  scale;
        logic [ROW_W-1:0]    row;
        logic                last;
    } t_item;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    binary_code_asymmetric_distance_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state
    logic [QW-1:0]     query_mem [QDEPTH];
    longint            dot_acc   = 0;
    int                row_bytes = 0;
    logic [RDIM_W-1:0] cfg_dim   = ROUTE_DIM_RST;
    logic [RCNT_W-1:0] cfg_rows  = ROW_COUNT_RST;
    t_result           exp_scores [$];

    // stimulus side
    t_item             in_items [$];
    bit                loaded [QDEPTH];
    int                prefix   = 0;
    int                gen_dim  = QDEPTH;
    int                gen_rows = 1048576;

    // handshake bookkeeping
    bit                in_fire   = 0;
    bit                out_fire  = 0;
    bit                drv_busy  = 0;
    bit                in_calm   = 0;
    bit                out_calm  = 0;
    int                gap_left  = 0;
    int                ready_wait = 0;
    int                err_count = 0;
    t_item             cur;
    t_result           got_want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_count++;
        $display("%0t MISMATCH %s: got %h expected %h", $time, what, got, want);
    endtask

    function automatic int draw_wait(bit calm);
        if (calm || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    task automatic predict_distance(logic [IN_DATA_W-1:0] data, logic op, logic last);
        int      dim;
        int      d;
        longint  s;
        longint  val;
        t_result r;
        if (op == OP_LOAD) begin
            query_mem[data[9:0]] = data[25:10];
            return;
        end
        dim = (cfg_dim > QDEPTH) ? QDEPTH : int'(cfg_dim);
        for (int lane = 0; lane < LANES; lane++) begin
            d = row_bytes * LANES + lane;
            if (d < dim) begin
                val = longint'($signed(query_mem[d]));
                dot_acc += data[26 + lane] ? val : -val;
            end
        end
        if (row_bytes < MAX_BYTES)
            row_bytes++;
        if (last) begin
            s = longint'(data[49:34]);
            r.row = data[69:50];
            r.err = ({1'b0, data[69:50]} >= cfg_rows);
            if (r.err) begin
                val = 0;
            end else begin
                val = longint'(dim) * s * s - 32 * s * dot_acc;
                if (val > SCORE_HI)
                    val = SCORE_HI;
                if (val < SCORE_LO)
                    val = SCORE_LO;
            end
            r.score = val[SCORE_W-1:0];
            exp_scores.push_back(r);
            dot_acc   = 0;
            row_bytes = 0;
        end
    endtask

    // sample at the rising edge: results first, then config and input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire  = 0;
            out_fire = 0;
        end else begin
            out_fire = m_axis_tvalid && m_axis_tready;
            in_fire  = s_axis_tvalid && s_axis_tready;
            if (out_fire) begin
                if (exp_scores.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
                end else begin
                    got_want = exp_scores.pop_front();
                    if (m_axis_tdata[47:0] !== got_want.score)
                        report_mismatch("score", 64'(m_axis_tdata[47:0]),
                                        64'(got_want.score));
                    if (m_axis_tdata[67:48] !== got_want.row)
                        report_mismatch("scored_row", 64'(m_axis_tdata[67:48]),
                                        64'(got_want.row));
                    if (m_axis_tuser[0] !== got_want.err)
                        report_mismatch("id_error", 64'(m_axis_tuser[0]),
                                        64'(got_want.err));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROUTE_DIM: cfg_dim  = i_cfg_data[RDIM_W-1:0];
                    REG_ROW_COUNT: cfg_rows = i_cfg_data[RCNT_W-1:0];
                    default: ;
                endcase
            end
            if (in_fire)
                predict_distance(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire)
                drv_busy = 0;
            if (!drv_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (in_items.size() > 0) begin
                    cur = in_items.pop_front();
                    s_axis_tdata  <= {2'b00, cur.row, cur.scale, cur.code, cur.qval, cur.qidx};
                    s_axis_tuser  <= cur.op;
                    s_axis_tlast  <= cur.last;
                    s_axis_tvalid <= 1'b1;
                    drv_busy = 1;
                    if ($urandom_range(0, 39) == 0)
                        in_calm = !in_calm;
                    gap_left = draw_wait(in_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) begin
                if ($urandom_range(0, 39) == 0)
                    out_calm = !out_calm;
                ready_wait = draw_wait(out_calm);
            end
            if (ready_wait > 0) begin
                ready_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic t_item rand_item();
        t_item it;
        it.op    = 1'($urandom_range(0, 1));
        it.qidx  = QIDX_W'($urandom_range(0, QDEPTH - 1));
        it.qval  = QW'($urandom_range(0, 65535));
        it.code  = CODE_W'($urandom_range(0, 255));
        it.scale = SCALE_W'($urandom_range(0, 65535));
        it.row   = ROW_W'($urandom_range(0, 1048575));
        it.last  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic logic [QW-1:0] rand_qval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 15)
            return 16'h8000;
        if (r < 20)
            return 16'h7FFF;
        return QW'($urandom_range(0, 65535));
    endfunction

    function automatic logic [SCALE_W-1:0] rand_scale();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return SCALE_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [CODE_W-1:0] rand_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return CODE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [ROW_W-1:0] rand_row_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15 && gen_rows > 0 && gen_rows <= 1048576)
            return ROW_W'(gen_rows - 1);
        if (r < 30 && gen_rows < 1048576)
            return ROW_W'(gen_rows);
        if (r < 35)
            return '1;
        return ROW_W'($urandom_range(0, 1048575));
    endfunction

    // longest row that reads only loaded query entries
    function automatic int row_limit();
        if (gen_dim <= prefix)
            return MAX_BYTES + 12;
        return prefix / LANES;
    endfunction

    function automatic int pick_len(int maxb);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, (maxb < 4) ? maxb : 4);
        if (r < 92)
            return $urandom_range(1, (maxb < 20) ? maxb : 20);
        return $urandom_range(1, maxb);
    endfunction

    task automatic add_load(int idx, logic [QW-1:0] val);
        t_item it;
        it = rand_item();
        it.op   = OP_LOAD;
        it.qidx = QIDX_W'(idx);
        it.qval = val;
        in_items.push_back(it);
        loaded[idx] = 1;
        while (prefix < QDEPTH && loaded[prefix])
            prefix++;
    endtask

    task automatic add_row(int nbytes, logic [SCALE_W-1:0] scale, logic [ROW_W-1:0] id,
                           int code);
        t_item it;
        for (int k = 0; k < nbytes; k++) begin
            it = rand_item();
            it.op   = OP_SCORE;
            it.code = (code >= 0) ? CODE_W'(code) : rand_code();
            it.last = (k == nbytes - 1);
            if (it.last) begin
                it.scale = scale;
                it.row   = id;
            end
            in_items.push_back(it);
        end
    endtask

    task automatic run_phase(int budget);
        int done;
        int maxb;
        int n;
        done = 0;
        while (done < budget) begin
            maxb = row_limit();
            if (maxb == 0 || $urandom_range(0, 99) < 35) begin
                if ($urandom_range(0, 99) < 65 && prefix < QDEPTH)
                    add_load(prefix, rand_qval());
                else
                    add_load($urandom_range(0, QDEPTH - 1), rand_qval());
                done++;
            end else begin
                n = pick_len(maxb);
                add_row(n, rand_scale(), rand_row_id(), -1);
                done += n;
            end
        end
    endtask

    task automatic wait_drained();
        int guard;
        while (in_items.size() != 0 || drv_busy)
            @(posedge i_clk);
        guard = 0;
        while (exp_scores.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (exp_scores.size() != 0) begin
            report_mismatch("missing results", 64'(exp_scores.size()), '0);
            exp_scores.delete();
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
    endtask

    task automatic set_config(int dim, int rows);
        wait_drained();
        write_reg(REG_ROUTE_DIM, dim);
        write_reg(REG_ROW_COUNT, rows);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        gen_dim  = (dim > QDEPTH) ? QDEPTH : dim;
        gen_rows = rows;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme query values, load with an ignored tlast, edge scales and ids
        add_load(0, 16'h8000);
        add_load(1, 16'h7FFF);
        add_load(2, 16'h0000);
        add_load(3, 16'h0001);
        add_load(4, 16'hFFFF);
        add_load(5, 16'h1234);
        add_load(6, 16'hFF00);
        add_load(7, 16'h00FF);
        in_items.push_back('{OP_LOAD, 10'd1023, 16'h5A5A, 8'hFF, 16'hFFFF, 20'hFFFFF, 1'b1});
        loaded[QDEPTH - 1] = 1;
        add_row(1, 16'hFFFF, 20'd0, 8'hFF);
        add_row(1, 16'hFFFF, 20'hFFFFF, 8'h00);
        add_row(1, 16'h0000, 20'd12345, 8'hA5);
        add_row(1, 16'h0001, 20'hAAAAA, 8'h5A);
        for (int i = 8; i < 16; i++)
            add_load(i, rand_qval());
        add_row(2, 16'h5555, 20'h55555, -1);

        // no dimensions in use, every id out of range
        set_config(0, 0);
        run_phase(30);

        set_config(1, 1);
        run_phase(30);

        // short route with rows running past the byte counter limit
        set_config(8, 1000);
        add_row(MAX_BYTES + 4, rand_scale(), 20'd999, -1);
        run_phase(40);

        set_config(37, $urandom_range(1, 1048575));
        run_phase(30);

        set_config($urandom_range(1, QDEPTH), 2097151);
        run_phase(30);

        // full-width rows need every query entry loaded
        set_config(QDEPTH, 1048576);
        for (int i = 0; i < QDEPTH; i++)
            if (!loaded[i])
                add_load(i, rand_qval());
        add_row(MAX_BYTES, 16'hFFFF, 20'd0, -1);
        run_phase(50);

        set_config(2047, 1048575);
        run_phase(30);

        wait_drained();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bcad_pkg.sv
rtl/core/bcad_ram.sv
rtl/core/bcad_lane.sv
rtl/core/bcad_merge.sv
rtl/core/bcad_fifo.sv
rtl/core/binary_code_asymmetric_distance_top.sv
bench/tb_binary_code_asymmetric_distance_top.sv
